/* src/dtrb_pkg.sv */
// Package for the decimating trace ring buffer.
// Holds the item structs, kind codes, value limits and divider handshake types.
// No dependencies.
package dtrb_pkg;

  // Width of a stored sample value and of the iteration count.
  localparam int SAMPLE_BITS = 32;
  localparam int ITER_BITS = 32;
  localparam int OFFSET_BITS = 8;
  localparam int INTERVAL_BITS = 16;
  localparam int LENGTH_BITS = 9;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SAMPLE_INTERVAL = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRACE_LENGTH = 1'd1;

  // Item kinds.
  localparam logic [1:0] KIND_OFFER = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Extremum start values after reset or clear.
  localparam logic signed [SAMPLE_BITS-1:0] VALUE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] VALUE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Serial divider: one quotient bit per cycle.
  localparam int DIV_STEPS = 32;
  localparam int DIV_COUNT_BITS = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [ITER_BITS-1:0] iteration;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [OFFSET_BITS-1:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic signed [SAMPLE_BITS-1:0] read_data;
    logic [ITER_BITS-1:0] read_iteration;
    logic read_valid;
    logic [ITER_BITS-1:0] window_low;
    logic [ITER_BITS-1:0] window_high;
    logic [ITER_BITS-1:0] window_span;
    logic signed [SAMPLE_BITS-1:0] overall_min;
    logic signed [SAMPLE_BITS-1:0] overall_max;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

/* src/dtrb_div.sv */
// Serial restoring divider, 32-bit dividend and divisor, one quotient bit per cycle.
// Depends on dtrb_pkg for the request and response structs.
module dtrb_div (
  input  logic                clk,
  input  logic                rst,
  input  dtrb_pkg::div_req_t  req,
  output dtrb_pkg::div_rsp_t  rsp
);

  logic                                run;
  logic                                done;
  logic [dtrb_pkg::DIV_COUNT_BITS-1:0] cnt;
  logic [31:0]                         quo;
  logic [31:0]                         rem;
  logic [31:0]                         dsr;
  logic [32:0]                         shifted;
  logic [32:0]                         diff;
  logic                                fits;

  // One trial subtraction of the shifted partial remainder.
  assign shifted = {rem, quo[31]};
  assign diff = shifted - {1'b0, dsr};
  assign fits = !diff[32];

  // Control: run for a fixed number of steps, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == dtrb_pkg::DIV_COUNT_BITS'(dtrb_pkg::DIV_STEPS - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits shift out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (run) begin
      quo <= {quo[30:0], fits};
      rem <= fits ? diff[31:0] : shifted[31:0];
    end
  end

  assign rsp.done = done;
  assign rsp.busy = run;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;

endmodule

/* src/dtrb_mem.sv */
// Trace sample memory: one write port and one read port, registered read data.
// Depends on dtrb_pkg for the sample width.
module dtrb_mem #(
  parameter int DEPTH = 256,
  parameter int ADDR_BITS = 8
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [ADDR_BITS-1:0]             wr_addr,
  input  logic [dtrb_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic                             rd_en,
  input  logic [ADDR_BITS-1:0]             rd_addr,
  output logic [dtrb_pkg::SAMPLE_BITS-1:0] rd_data
);

  logic [dtrb_pkg::SAMPLE_BITS-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/decimating_trace_ring_buffer.sv */
// Decimating trace ring buffer with window bounds and running minimum and maximum.
// From accept to result: offer runs a serial divide by the interval, plus a modulo divide when
// the advanced oldest pointer needs one by a shrunken length; valid read passes S_RD and S_RDW,
// after a modulo divide if its slot index needs one by the length; clear zeroes every row,
// one per cycle; invalid read and unused kind go to S_DONE. One item at a time: the next is
// accepted in the cycle after its result is loaded. Sync reset; memory undefined until written.
module decimating_trace_ring_buffer #(
  parameter int TRACE_DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [dtrb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [dtrb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  dtrb_pkg::in_item_t                     in_item,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output dtrb_pkg::out_item_t                    out_item
);

  localparam int AW = $clog2(TRACE_DEPTH);
  localparam int LW = $clog2(TRACE_DEPTH + 1);
  localparam int TLW = (LW > dtrb_pkg::LENGTH_BITS) ? LW : dtrb_pkg::LENGTH_BITS;
  localparam int SW = ((AW > dtrb_pkg::OFFSET_BITS) ? AW : dtrb_pkg::OFFSET_BITS) + 1;
  localparam int PW = LW + dtrb_pkg::INTERVAL_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV_Q = 3'd1;
  localparam logic [2:0] S_DIV_PTR = 3'd2;
  localparam logic [2:0] S_DIV_IDX = 3'd3;
  localparam logic [2:0] S_RD = 3'd4;
  localparam logic [2:0] S_RDW = 3'd5;
  localparam logic [2:0] S_CLR = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;

  // Configuration registers.
  logic [dtrb_pkg::INTERVAL_BITS-1:0] sample_interval;
  logic [TLW-1:0]                     trace_length;

  // Trace state kept in flip-flops.
  logic [AW-1:0]                           oldest_slot;
  logic [dtrb_pkg::ITER_BITS-1:0]          low_bound;
  logic [dtrb_pkg::ITER_BITS-1:0]          high_bound;
  logic [dtrb_pkg::ITER_BITS-1:0]          span_reg;
  logic signed [dtrb_pkg::SAMPLE_BITS-1:0] min_seen;
  logic signed [dtrb_pkg::SAMPLE_BITS-1:0] max_seen;

  // Item in work and its pending result.
  dtrb_pkg::in_item_t             item;
  logic                           res_accepted;
  logic [dtrb_pkg::SAMPLE_BITS-1:0] res_rdata;
  logic [dtrb_pkg::ITER_BITS-1:0] res_riter;
  logic                           res_rvalid;
  logic [AW-1:0]                  rd_idx;
  logic [AW-1:0]                  clr_addr;

  // Effective interval and length.
  logic [dtrb_pkg::INTERVAL_BITS-1:0] ivl;
  logic [LW-1:0]                      len;
  logic [SW-1:0]                      len_s;
  logic [dtrb_pkg::ITER_BITS-1:0]     ivl32;

  assign ivl = (sample_interval == '0) ? dtrb_pkg::INTERVAL_BITS'(1) : sample_interval;
  assign ivl32 = dtrb_pkg::ITER_BITS'(ivl);
  always_comb begin
    if (trace_length == '0) begin
      len = LW'(1);
    end else if (trace_length > TLW'(TRACE_DEPTH)) begin
      len = LW'(TRACE_DEPTH);
    end else begin
      len = LW'(trace_length);
    end
  end
  assign len_s = SW'(len);

  // Read address arithmetic: offset from the oldest slot, wrapped by the length.
  logic                           accept;
  logic [dtrb_pkg::ITER_BITS-1:0] rd_dist;
  logic [dtrb_pkg::ITER_BITS-1:0] fill_gap;
  logic                           rd_ok;
  logic [SW-1:0]                  rd_w;
  logic [SW-1:0]                  rd_sub;
  logic                           rd_direct;
  logic                           rd_once;

  assign accept = in_valid && !in_stall;
  assign rd_dist = dtrb_pkg::ITER_BITS'(in_item.read_offset) * ivl32;
  assign fill_gap = high_bound - low_bound;
  assign rd_ok = (SW'(in_item.read_offset) < len_s) && (rd_dist < fill_gap);
  assign rd_w = SW'(oldest_slot) + SW'(in_item.read_offset);
  assign rd_sub = rd_w - len_s;
  assign rd_direct = rd_w < len_s;
  assign rd_once = rd_sub < len_s;

  // Oldest pointer advance, wrapped by the length.
  logic [SW-1:0] pt_w;
  logic [SW-1:0] pt_sub;
  logic          pt_direct;
  logic          pt_once;

  assign pt_w = SW'(oldest_slot) + SW'(1);
  assign pt_sub = pt_w - len_s;
  assign pt_direct = pt_w < len_s;
  assign pt_once = pt_sub < len_s;

  // Divider and offer evaluation.
  dtrb_pkg::div_req_t div_req;
  dtrb_pkg::div_rsp_t div_rsp;
  logic               offer_keep;
  logic               offer_ring;
  logic [PW-1:0]      fill_prod;
  logic [dtrb_pkg::ITER_BITS-1:0] high_next;
  logic [dtrb_pkg::ITER_BITS-1:0] low_next;

  assign offer_keep = (state == S_DIV_Q) && div_rsp.done && (div_rsp.remainder == '0);
  assign offer_ring = div_rsp.quotient >= dtrb_pkg::ITER_BITS'(len);
  assign fill_prod = PW'(len) * PW'(ivl);
  assign high_next = high_bound + ivl32;
  assign low_next = low_bound + ivl32;

  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = item.iteration;
    div_req.divisor = ivl32;
    if (accept && (in_item.kind == dtrb_pkg::KIND_OFFER)) begin
      div_req.start = 1'b1;
      div_req.dividend = in_item.iteration;
    end else if (accept && (in_item.kind == dtrb_pkg::KIND_READ) && rd_ok &&
                 !rd_direct && !rd_once) begin
      div_req.start = 1'b1;
      div_req.dividend = 32'(rd_w);
      div_req.divisor = 32'(len);
    end else if (offer_keep && offer_ring && !pt_direct && !pt_once) begin
      div_req.start = 1'b1;
      div_req.dividend = 32'(pt_w);
      div_req.divisor = 32'(len);
    end
  end

  dtrb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Memory port control.
  logic                             mem_wr_en;
  logic [AW-1:0]                    mem_wr_addr;
  logic [dtrb_pkg::SAMPLE_BITS-1:0] mem_wr_data;
  logic [dtrb_pkg::SAMPLE_BITS-1:0] mem_rd_data;

  always_comb begin
    mem_wr_en = 1'b0;
    mem_wr_addr = clr_addr;
    mem_wr_data = '0;
    if (state == S_CLR) begin
      mem_wr_en = 1'b1;
    end else if (offer_keep) begin
      mem_wr_en = 1'b1;
      mem_wr_addr = offer_ring ? oldest_slot : AW'(div_rsp.quotient);
      mem_wr_data = item.sample_value;
    end
  end

  dtrb_mem #(
    .DEPTH     (TRACE_DEPTH),
    .ADDR_BITS (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (state == S_RD),
    .rd_addr (rd_idx),
    .rd_data (mem_rd_data)
  );

  assign in_stall = (state != S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_interval <= dtrb_pkg::INTERVAL_BITS'(1);
      trace_length <= TLW'(TRACE_DEPTH);
    end else if (cfg_write) begin
      case (cfg_index)
        dtrb_pkg::CFG_SAMPLE_INTERVAL: sample_interval <= cfg_data;
        dtrb_pkg::CFG_TRACE_LENGTH: trace_length <= TLW'(cfg_data[dtrb_pkg::LENGTH_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer and trace state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      oldest_slot <= '0;
      low_bound <= '0;
      high_bound <= '0;
      span_reg <= '0;
      min_seen <= dtrb_pkg::VALUE_MAX;
      max_seen <= dtrb_pkg::VALUE_MIN;
      clr_addr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_item;
            res_accepted <= 1'b0;
            res_rdata <= '0;
            res_riter <= '0;
            res_rvalid <= 1'b0;
            case (in_item.kind)
              dtrb_pkg::KIND_OFFER: begin
                state <= S_DIV_Q;
              end
              dtrb_pkg::KIND_READ: begin
                res_riter <= low_bound + rd_dist;
                res_rvalid <= rd_ok;
                rd_idx <= rd_direct ? AW'(rd_w) : AW'(rd_sub);
                if (!rd_ok) begin
                  state <= S_DONE;
                end else if (rd_direct || rd_once) begin
                  state <= S_RD;
                end else begin
                  state <= S_DIV_IDX;
                end
              end
              dtrb_pkg::KIND_CLEAR: begin
                oldest_slot <= '0;
                low_bound <= '0;
                high_bound <= '0;
                span_reg <= '0;
                min_seen <= dtrb_pkg::VALUE_MAX;
                max_seen <= dtrb_pkg::VALUE_MIN;
                clr_addr <= '0;
                state <= S_CLR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DIV_Q: begin
          if (div_rsp.done) begin
            state <= S_DONE;
            if (div_rsp.remainder == '0) begin
              res_accepted <= 1'b1;
              high_bound <= high_next;
              if (item.sample_value > max_seen) begin
                max_seen <= item.sample_value;
              end
              if (item.sample_value < min_seen) begin
                min_seen <= item.sample_value;
              end
              if (offer_ring) begin
                // Ring phase: overwrite the oldest slot and slide the window.
                low_bound <= low_next;
                span_reg <= high_next - low_next;
                if (pt_direct) begin
                  oldest_slot <= AW'(pt_w);
                end else if (pt_once) begin
                  oldest_slot <= AW'(pt_sub);
                end else begin
                  state <= S_DIV_PTR;
                end
              end else begin
                // Fill phase: the slot follows from the quotient.
                span_reg <= 32'(fill_prod) - low_bound;
              end
            end
          end
        end
        S_DIV_PTR: begin
          if (div_rsp.done) begin
            oldest_slot <= AW'(div_rsp.remainder);
            state <= S_DONE;
          end
        end
        S_DIV_IDX: begin
          if (div_rsp.done) begin
            rd_idx <= AW'(div_rsp.remainder);
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          res_rdata <= mem_rd_data;
          state <= S_DONE;
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TRACE_DEPTH - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_item.accepted <= res_accepted;
      out_item.read_data <= res_rdata;
      out_item.read_iteration <= res_riter;
      out_item.read_valid <= res_rvalid;
      out_item.window_low <= low_bound;
      out_item.window_high <= high_bound;
      out_item.window_span <= span_reg;
      out_item.overall_min <= min_seen;
      out_item.overall_max <= max_seen;
    end
  end

  // An item is either a stored sample or a valid read, never both.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.accepted && out_item.read_valid))
    else $error("result reports both a stored sample and a valid read");

  // The divider is never restarted while it is still working.
  assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // During the clearing sweep the window has already been emptied.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> (low_bound == '0 && high_bound == '0 && span_reg == '0))
    else $error("window not empty during clear sweep");

endmodule
